// ===== rtl/pau_pkg.sv =====
// Shared types and constants of the polynomial arithmetic unit.
package pau_pkg;

   // Fixed field widths
   localparam int COEF_W    = 32;
   localparam int RES_DEG_W = 6;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 1;

   // Operation codes held in the mode register
   localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MUL  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EVAL = 2'd3;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EVAL_POINT = 1'b1;

   // Per-cycle control handed from the sequencer to the result head
   typedef struct packed {
      logic                 clear;
      logic [MODE_W-1:0]    mode;
      logic                 a_live;
      logic                 b_live;
      logic                 emit;
      logic                 last;
      logic [RES_DEG_W-1:0] degree;
   } head_ctl_type;

endpackage

// ===== rtl/polynomial_arithmetic_unit.sv =====
// Top level: coefficient loading, run sequencer, cell chain and result head.
//
//  channel  ports        handshake                      beat
//  request  req_*        start & !busy                  target, coefficient, last
//  response rsp_*        rsp_strobe, one cycle each     result_value, result_degree, result_last
//  config   csr_*        csr_write_enable               csr_index, csr_write_data
//
// A coefficient beat is taken whenever start is high and busy is low. A beat that finishes a
// run (last of B in add, subtract or multiply mode, last of A in evaluate mode) starts a
// run, timed by the run counter that walks the product through the cell chain; busy is
// high until the counter reaches its end. Sum and product beats come out lowest degree
// first; evaluate mode gives a single value. Each result beat is registered in the head.
// Reset is synchronous; the coefficient stores are not cleared. Results cannot stall.
module polynomial_arithmetic_unit import pau_pkg::*; #(
   parameter int MAX_DEGREE = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_target,
   input  logic signed [COEF_W-1:0]    req_coefficient,
   input  logic                        req_last,
   output logic                        rsp_strobe,
   output logic signed [COEF_W-1:0]    rsp_result_value,
   output logic [RES_DEG_W-1:0]        rsp_result_degree,
   output logic                        rsp_result_last,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [COEF_W-1:0]           csr_write_data
);

   localparam int DEPTH    = MAX_DEGREE + 1;
   localparam int DEG_W    = $clog2(DEPTH);
   localparam int IDX_W    = $clog2(DEPTH + 1);
   localparam int RUN_LAST = 2 * DEPTH;
   localparam int CNT_W    = $clog2(RUN_LAST + 1);
   localparam int TOP_W    = DEG_W + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [COEF_W-1:0] eval_point_ff, eval_point_in;
   logic [DEG_W-1:0]  degree_a_ff, degree_a_in;
   logic [DEG_W-1:0]  degree_b_ff, degree_b_in;
   logic [IDX_W-1:0]  load_idx_a_ff, load_idx_a_in;
   logic [IDX_W-1:0]  load_idx_b_ff, load_idx_b_in;
   logic              state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              accept, go, run, rotate, rot_b;
   logic              load_a_sel, load_b_sel;
   logic              a_live, b_live;
   logic [DEG_W-1:0]  top_sum;
   logic [TOP_W-1:0]  top_mul;
   logic [CNT_W-1:0]  mul_k;
   logic [COEF_W-1:0] mul_x;
   head_ctl_type      ctl;

   logic [COEF_W-1:0] a_chain [DEPTH];
   logic [COEF_W-1:0] b_chain [DEPTH];
   logic [COEF_W-1:0] s_chain [DEPTH+1];

   // Configuration registers
   always_comb begin
      mode_in       = mode_ff;
      eval_point_in = eval_point_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:       mode_in       = csr_write_data[MODE_W-1:0];
            CSR_EVAL_POINT: eval_point_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_MUL;
         eval_point_ff <= '0;
      end else begin
         mode_ff       <= mode_in;
         eval_point_ff <= eval_point_in;
      end
   end

   // Coefficient load indexes and degrees
   assign busy       = (state_ff == ST_RUN);
   assign accept     = start && !busy;
   assign load_a_sel = accept && !req_target;
   assign load_b_sel = accept && req_target;

   always_comb begin
      load_idx_a_in = load_idx_a_ff;
      degree_a_in   = degree_a_ff;
      load_idx_b_in = load_idx_b_ff;
      degree_b_in   = degree_b_ff;
      if (load_a_sel) begin
         if (req_last) begin
            degree_a_in   = (load_idx_a_ff < IDX_W'(DEPTH)) ?
                            load_idx_a_ff[DEG_W-1:0] : DEG_W'(MAX_DEGREE);
            load_idx_a_in = '0;
         end else if (load_idx_a_ff < IDX_W'(DEPTH)) begin
            load_idx_a_in = load_idx_a_ff + 1'b1;
         end
      end
      if (load_b_sel) begin
         if (req_last) begin
            degree_b_in   = (load_idx_b_ff < IDX_W'(DEPTH)) ?
                            load_idx_b_ff[DEG_W-1:0] : DEG_W'(MAX_DEGREE);
            load_idx_b_in = '0;
         end else if (load_idx_b_ff < IDX_W'(DEPTH)) begin
            load_idx_b_in = load_idx_b_ff + 1'b1;
         end
      end
   end

   // Run sequencer
   assign go = accept && req_last &&
               ((!req_target && (mode_ff == MODE_EVAL)) ||
                (req_target && (mode_ff != MODE_EVAL)));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (go) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff == CNT_W'(RUN_LAST)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         degree_a_ff   <= '0;
         degree_b_ff   <= '0;
         load_idx_a_ff <= '0;
         load_idx_b_ff <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         degree_a_ff   <= degree_a_in;
         degree_b_ff   <= degree_b_in;
         load_idx_a_ff <= load_idx_a_in;
         load_idx_b_ff <= load_idx_b_in;
      end
   end

   // Per-cycle run flags; A rotates once around the chain, B only for add/subtract
   assign run     = (state_ff == ST_RUN);
   assign rotate  = run && (cnt_ff < CNT_W'(DEPTH));
   assign rot_b   = rotate && ((mode_ff == MODE_ADD) || (mode_ff == MODE_SUB));
   assign a_live  = (cnt_ff <= CNT_W'(degree_a_ff));
   assign b_live  = (cnt_ff <= CNT_W'(degree_b_ff));
   assign top_sum = (degree_a_ff > degree_b_ff) ? degree_a_ff : degree_b_ff;
   assign top_mul = TOP_W'(degree_a_ff) + TOP_W'(degree_b_ff);
   assign mul_k   = cnt_ff - CNT_W'(2);
   assign mul_x   = (run && (mode_ff == MODE_MUL) && a_live) ? a_chain[0] : '0;

   // Head control
   always_comb begin
      ctl.clear  = reset || !run;
      ctl.mode   = mode_ff;
      ctl.a_live = a_live;
      ctl.b_live = b_live;
      ctl.emit   = 1'b0;
      ctl.last   = 1'b0;
      ctl.degree = RES_DEG_W'(cnt_ff);
      unique case (mode_ff)
         MODE_ADD, MODE_SUB: begin
            ctl.emit = run && (cnt_ff <= CNT_W'(top_sum));
            ctl.last = (cnt_ff == CNT_W'(top_sum));
         end
         MODE_MUL: begin
            ctl.emit   = run && (cnt_ff >= CNT_W'(2)) && (mul_k <= CNT_W'(top_mul));
            ctl.last   = (mul_k == CNT_W'(top_mul));
            ctl.degree = RES_DEG_W'(mul_k);
         end
         MODE_EVAL: begin
            ctl.emit   = run && (cnt_ff == CNT_W'(DEPTH + 1));
            ctl.last   = 1'b1;
            ctl.degree = '0;
         end
      endcase
   end

   // Cell chain; the partial-sum chain ends in zero above the top cell
   assign s_chain[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pau_cell #(
         .IDX   (i),
         .DEG_W (DEG_W)
      ) u_cell (
         .clock     (clock),
         .clear     (ctl.clear),
         .load_a    (load_a_sel && (load_idx_a_ff == IDX_W'(i))),
         .load_b    (load_b_sel && (load_idx_b_ff == IDX_W'(i))),
         .load_data (req_coefficient),
         .rot_a     (rotate),
         .rot_b     (rot_b),
         .a_from_up (a_chain[(i + 1) % DEPTH]),
         .b_from_up (b_chain[(i + 1) % DEPTH]),
         .x         (mul_x),
         .deg_b     (degree_b_ff),
         .s_from_up (s_chain[i + 1]),
         .a_out     (a_chain[i]),
         .b_out     (b_chain[i]),
         .s_out     (s_chain[i])
      );
   end

   // Result head
   pau_head u_head (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .a_head            (a_chain[0]),
      .b_head            (b_chain[0]),
      .s_head            (s_chain[0]),
      .x_point           (eval_point_ff),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_value  (rsp_result_value),
      .rsp_result_degree (rsp_result_degree),
      .rsp_result_last   (rsp_result_last)
   );

endmodule

// ===== rtl/pau_cell.sv =====
// One coefficient cell: holds A[k] and B[k], one MAC stage of the product chain.
module pau_cell import pau_pkg::*; #(
   parameter int IDX   = 0,
   parameter int DEG_W = 5
) (
   input  logic              clock,
   input  logic              clear,
   input  logic              load_a,
   input  logic              load_b,
   input  logic [COEF_W-1:0] load_data,
   input  logic              rot_a,
   input  logic              rot_b,
   input  logic [COEF_W-1:0] a_from_up,
   input  logic [COEF_W-1:0] b_from_up,
   input  logic [COEF_W-1:0] x,
   input  logic [DEG_W-1:0]  deg_b,
   input  logic [COEF_W-1:0] s_from_up,
   output logic [COEF_W-1:0] a_out,
   output logic [COEF_W-1:0] b_out,
   output logic [COEF_W-1:0] s_out
);

   logic [COEF_W-1:0]   a_ff, a_in;
   logic [COEF_W-1:0]   b_ff, b_in;
   logic [COEF_W-1:0]   p_ff, p_in;
   logic [COEF_W-1:0]   s_ff, s_in;
   logic [COEF_W-1:0]   b_eff;
   logic [2*COEF_W-1:0] prod;

   // Coefficient storage: written on load, rotated toward cell 0 during a run
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (load_a) begin
         a_in = load_data;
      end else if (rot_a) begin
         a_in = a_from_up;
      end
      if (load_b) begin
         b_in = load_data;
      end else if (rot_b) begin
         b_in = b_from_up;
      end
   end

   // Transposed-form MAC: product stage, then add the partial sum from above
   assign b_eff = (deg_b >= DEG_W'(IDX)) ? b_ff : '0;
   assign prod  = b_eff * x;

   always_comb begin
      if (clear) begin
         p_in = '0;
         s_in = '0;
      end else begin
         p_in = prod[COEF_W-1:0];
         s_in = p_ff + s_from_up;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
      s_ff <= s_in;
   end

   assign a_out = a_ff;
   assign b_out = b_ff;
   assign s_out = s_ff;

endmodule

// ===== rtl/pau_head.sv =====
// Result head: add/subtract, product select, Horner-free power evaluation, and the result register.
module pau_head import pau_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  head_ctl_type                ctl,
   input  logic [COEF_W-1:0]           a_head,
   input  logic [COEF_W-1:0]           b_head,
   input  logic [COEF_W-1:0]           s_head,
   input  logic [COEF_W-1:0]           x_point,
   output logic                        rsp_strobe,
   output logic signed [COEF_W-1:0]    rsp_result_value,
   output logic [RES_DEG_W-1:0]        rsp_result_degree,
   output logic                        rsp_result_last
);

   logic [COEF_W-1:0]   a_m, b_m;
   logic [COEF_W-1:0]   pw_ff, pw_in;
   logic [COEF_W-1:0]   term_ff, term_in;
   logic [COEF_W-1:0]   acc_ff, acc_in;
   logic [2*COEF_W-1:0] pw_prod, term_prod;
   logic [COEF_W-1:0]   value;
   logic                strobe_ff, strobe_in;
   logic [COEF_W-1:0]   value_ff;
   logic [RES_DEG_W-1:0] degree_ff;
   logic                last_ff;

   // Coefficients past each degree read as zero
   assign a_m = ctl.a_live ? a_head : '0;
   assign b_m = ctl.b_live ? b_head : '0;

   // Evaluation: power x^n and term a[n]*x^n are each registered, then summed
   assign pw_prod   = pw_ff * x_point;
   assign term_prod = a_m * pw_ff;

   always_comb begin
      if (ctl.clear) begin
         pw_in   = COEF_W'(1);
         term_in = '0;
         acc_in  = '0;
      end else begin
         pw_in   = pw_prod[COEF_W-1:0];
         term_in = term_prod[COEF_W-1:0];
         acc_in  = acc_ff + term_ff;
      end
   end

   always_ff @(posedge clock) begin
      pw_ff   <= pw_in;
      term_ff <= term_in;
      acc_ff  <= acc_in;
   end

   // Result select
   always_comb begin
      unique case (ctl.mode)
         MODE_ADD:  value = a_m + b_m;
         MODE_SUB:  value = a_m - b_m;
         MODE_MUL:  value = s_head;
         MODE_EVAL: value = acc_ff;
      endcase
   end

   // Result register: one beat per strobe
   assign strobe_in = ctl.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value;
      degree_ff <= ctl.degree;
      last_ff   <= ctl.last;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_value  = value_ff;
   assign rsp_result_degree = degree_ff;
   assign rsp_result_last   = last_ff;

endmodule
